@@ rtl/cfp_pkg.sv @@
// Package for the camera frame parser: frame constants, widths and the
// record that travels from the frame front end to the result back end.
// No dependencies.
package cfp_pkg;

    // Frame framing bytes and the command code that yields a result.
    localparam logic [7:0] HDR_BYTE  = 8'hEF;
    localparam logic [7:0] TAIL_BYTE = 8'hFE;
    localparam logic [7:0] CMD_A     = 8'h41;

    // Payload bytes kept per frame; later bytes are only summed.
    localparam int         STORE_DEPTH = 7;
    localparam int         STORE_IDX_W = $clog2(STORE_DEPTH);
    localparam logic [7:0] STORE_LEN   = 8'(STORE_DEPTH);

    // Result field width and the default depth of the front-to-back queue.
    localparam int RESULT_W          = 15;
    localparam int QUEUE_DEPTH_DEF   = 2;

    // Stored payload bytes 1 to 6 of a good frame, element 0 is byte 1.
    typedef logic [5:0][7:0] cfp_digits_t;

endpackage

@@ rtl/cfp_front.sv @@
// Frame front end: hunts for the header, tracks length, sum and tail, keeps
// the first payload bytes and pushes a record for each good 'A' frame.
// Depends on cfp_pkg.
module cfp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_valid,
    input  logic [7:0]          rx_byte,
    output logic                push,
    output cfp_pkg::cfp_digits_t push_digits
);
    import cfp_pkg::*;

    // Phase codes.
    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_DATA = 3'd2;
    localparam logic [2:0] PH_SUM  = 3'd3;
    localparam logic [2:0] PH_TAIL = 3'd4;

    logic [2:0] phase_reg, phase_next;
    logic [7:0] frame_length_reg, frame_length_next;
    logic [7:0] byte_count_reg, byte_count_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic [7:0] store_reg [STORE_DEPTH];
    logic       store_we;

    // Phase sequencing on each accepted byte.
    always_comb begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        byte_count_next   = byte_count_reg;
        running_sum_next  = running_sum_reg;
        push              = 1'b0;
        store_we          = 1'b0;
        if (byte_valid) begin
            case (phase_reg)
                PH_HUNT: begin
                    if (rx_byte == HDR_BYTE) begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    running_sum_next  = 8'd0;
                    frame_length_next = rx_byte;
                    byte_count_next   = 8'd0;
                    phase_next        = PH_DATA;
                end
                PH_DATA: begin
                    store_we         = (byte_count_reg < STORE_LEN);
                    running_sum_next = running_sum_reg + rx_byte;
                    byte_count_next  = byte_count_reg + 8'd1;
                    if (byte_count_next >= frame_length_reg) begin
                        phase_next = PH_SUM;
                    end
                end
                PH_SUM: begin
                    phase_next = (rx_byte == running_sum_reg) ? PH_TAIL : PH_HUNT;
                end
                PH_TAIL: begin
                    push       = (rx_byte == TAIL_BYTE) && (store_reg[0] == CMD_A);
                    phase_next = PH_HUNT;
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HUNT;
            frame_length_reg <= 8'd0;
            byte_count_reg   <= 8'd0;
            running_sum_reg  <= 8'd0;
        end else begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            byte_count_reg   <= byte_count_next;
            running_sum_reg  <= running_sum_next;
        end
    end

    // Payload store, cleared at reset and kept across frames.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                store_reg[i] <= 8'd0;
            end
        end else if (store_we) begin
            store_reg[byte_count_reg[STORE_IDX_W-1:0]] <= rx_byte;
        end
    end

    // Bytes 1 to 6 form the record handed to the back end.
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            push_digits[i] = store_reg[i+1];
        end
    end

endmodule

@@ rtl/cfp_queue.sv @@
// Short queue between the frame front end and the result back end.
// Depends on cfp_pkg.
module cfp_queue #(
    parameter int DEPTH = cfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  cfp_pkg::cfp_digits_t          push_digits,
    input  logic                          pop,
    output cfp_pkg::cfp_digits_t          head_digits,
    output logic [$clog2(DEPTH+1)-1:0]    count
);
    import cfp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cfp_digits_t    mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    // Pointer advance with wrap at any depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_digits;
        end
    end

    assign head_digits = mem[rd_ptr_reg];
    assign count       = count_reg;

endmodule

@@ rtl/cfp_back.sv @@
// Result back end: weighs the stored digits of one queued frame and holds
// the result in an output register until the consumer takes it.
// Depends on cfp_pkg.
module cfp_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  cfp_pkg::cfp_digits_t head_digits,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata     // [14:0] target_width, [29:15] target_location
);
    import cfp_pkg::*;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [RESULT_W-1:0] width_reg, width_next;
    logic [RESULT_W-1:0] location_reg, location_next;

    // Three bytes weighted 100, 10 and 1; the largest sum fits in 15 bits.
    function automatic logic [RESULT_W-1:0] weigh3(input logic [7:0] a,
                                                    input logic [7:0] b,
                                                    input logic [7:0] c);
        logic [RESULT_W-1:0] sum;
        sum = RESULT_W'(a) * RESULT_W'(100) + RESULT_W'(b) * RESULT_W'(10) + RESULT_W'(c);
        return sum;
    endfunction

    // Take the next record whenever the output register is free or draining.
    assign pop = head_valid && (!m_tvalid_reg || m_tready);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        width_next    = width_reg;
        location_next = location_reg;
        if (pop) begin
            m_tvalid_next = 1'b1;
            width_next    = weigh3(head_digits[0], head_digits[1], head_digits[2]);
            location_next = weigh3(head_digits[3], head_digits[4], head_digits[5]);
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        width_reg    <= width_next;
        location_reg <= location_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, location_reg, width_reg};

endmodule

@@ rtl/camera_frame_parser.sv @@
// Camera frame parser: byte-serial frame receiver with an 8-bit sum check.
// Throughput: one byte transfer per cycle; the input stalls only while the
// front-to-back queue is full. After the transfer of the tail byte of a good
// 'A' frame, the record is written into the queue and, once the output
// register is free or draining, weighed into the output register, which
// raises m_tvalid. Reset (aresetn low, synchronous) returns to header hunt,
// clears the payload store, queue and output valid.
module camera_frame_parser #(
    parameter int QUEUE_DEPTH = cfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata     // [14:0] target_width, [29:15] target_location
);
    import cfp_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic           byte_valid;
    logic           push;
    logic           pop;
    cfp_digits_t    push_digits;
    cfp_digits_t    head_digits;
    logic [CW-1:0]  q_count;

    // A byte is taken whenever the queue has room for a possible result.
    assign s_tready   = (q_count != CW'(QUEUE_DEPTH));
    assign byte_valid = s_tvalid && s_tready;

    cfp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_valid  (byte_valid),
        .rx_byte     (s_tdata),
        .push        (push),
        .push_digits (push_digits)
    );

    cfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_digits (push_digits),
        .pop         (pop),
        .head_digits (head_digits),
        .count       (q_count)
    );

    cfp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (q_count != '0),
        .head_digits (head_digits),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // The queue never holds more records than its depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= CW'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    // A result is only pushed for an accepted byte, never into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> byte_valid && (q_count != CW'(QUEUE_DEPTH)))
        else $error("push without an accepted byte or into a full queue");

    // A record pushed with nothing popped raises the queue count by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> q_count == $past(q_count) + 1'b1)
        else $error("queue count did not follow a push");

    // A pop needs a waiting record and leads to a valid result next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (q_count != '0) ##1 m_tvalid)
        else $error("pop from empty queue or result not presented");

endmodule
